// File: sv/piecewise_affine_warp_map_macros.svh
// assertion macros for the warp map top level
`ifndef PIECEWISE_AFFINE_WARP_MAP_MACROS_SVH
`define PIECEWISE_AFFINE_WARP_MAP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PAWM_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PAWM_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pawm_pkg.sv
package pawm_pkg;

  // mesh and number format
  localparam int MAX_TRIANGLES = 128;
  localparam int FRAC_BITS     = 16;
  localparam int TRI_AW        = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int WIDE          = 66;

  // result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

  // register file
  localparam int NUM_REGS = 3;
  localparam int ADDR_W   = $clog2(4 * NUM_REGS);

  // outside markers in whole pixels
  localparam int OUTSIDE_WARP   = -1;
  localparam int OUTSIDE_UNWARP = -10000;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_VERTEX = 2'd1,
    CMD_PIXEL  = 2'd2
  } cmd_t;

  typedef enum logic [ADDR_W-3:0] {
    REG_X_OFFSET    = 2'd0,
    REG_Y_OFFSET    = 2'd1,
    REG_UNWARP_MODE = 2'd2
  } reg_idx_t;

  typedef logic signed [31:0] word_t;

  // six words: alpha0..2 beta0..2, or coefficients c0..c5
  typedef word_t [5:0] word6_t;

  // control and pixel data that travel down the pipeline
  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [TRI_AW-1:0] addr;
    logic              in_range;
    logic              on;
    word_t             xi;
    word_t             yi;
  } item_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } map_t;

  localparam logic signed [WIDE-1:0] POS_LIM = WIDE'(64'sd2147483647);
  localparam logic signed [WIDE-1:0] RND_HALF = WIDE'(1) <<< (FRAC_BITS - 1);

  // saturate to the full 32-bit range
  function automatic word_t sat32_f(input logic signed [WIDE-1:0] v);
    word_t r;
    if (v > POS_LIM) begin
      r = 32'sh7fffffff;
    end else if (v < -POS_LIM - WIDE'(1)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // saturate to the symmetric range, most negative code excluded
  function automatic word_t sat_sym_f(input logic signed [WIDE-1:0] v);
    word_t r;
    if (v > POS_LIM) begin
      r = 32'sh7fffffff;
    end else if (v < -POS_LIM) begin
      r = 32'sh80000001;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // s already holds the rounding half: floor shift, add base, saturate
  function automatic word_t round_add_sat_f(input logic signed [WIDE-1:0] s,
                                            input word_t base);
    logic signed [WIDE-1:0] t;
    t = (s >>> FRAC_BITS) + WIDE'(base);
    return sat32_f(t);
  endfunction

  localparam word_t MARK_WARP   = sat32_f(WIDE'(OUTSIDE_WARP) <<< FRAC_BITS);
  localparam word_t MARK_UNWARP = sat32_f(WIDE'(OUTSIDE_UNWARP) <<< FRAC_BITS);

endpackage

// File: sv/pawm_coef_gen.sv
module pawm_coef_gen import pawm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  item_t  s1,
  input  word6_t vals1,
  output item_t  s5,
  output word6_t coef5
);

  word6_t ab_mem [MAX_TRIANGLES];
  word6_t ab_rd;

  item_t s2, s3, s4;
  word_t dx1, dx2, dy1, dy2;
  word_t base_x2, base_y2, base_x3, base_y3, base_x4, base_y4;
  logic signed [63:0] pxa [3];
  logic signed [63:0] pxb [3];
  logic signed [63:0] pya [3];
  logic signed [63:0] pyb [3];
  logic signed [WIDE-1:0] sx4 [3];
  logic signed [WIDE-1:0] sy4 [3];

  // alpha beta store: load writes, vertex set reads, both at the first stage
  always_ff @(posedge clk) begin
    if (s1.valid && s1.cmd == CMD_LOAD && s1.in_range) begin
      ab_mem[s1.addr] <= vals1;
    end
    ab_rd <= ab_mem[s1.addr];
  end

  // edge vectors of the triangle
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= s1;
    end
    dx1     <= sat_sym_f(WIDE'($signed(vals1[1])) - WIDE'($signed(vals1[0])));
    dx2     <= sat_sym_f(WIDE'($signed(vals1[2])) - WIDE'($signed(vals1[0])));
    dy1     <= sat_sym_f(WIDE'($signed(vals1[4])) - WIDE'($signed(vals1[3])));
    dy2     <= sat_sym_f(WIDE'($signed(vals1[5])) - WIDE'($signed(vals1[3])));
    base_x2 <= vals1[0];
    base_y2 <= vals1[3];
  end

  // edge vectors times alpha and beta
  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else begin
      s3 <= s2;
    end
    base_x3 <= base_x2;
    base_y3 <= base_y2;
    for (int n = 0; n < 3; n++) begin
      pxa[n] <= dx1 * $signed(ab_rd[n]);
      pxb[n] <= dx2 * $signed(ab_rd[3+n]);
      pya[n] <= dy1 * $signed(ab_rd[n]);
      pyb[n] <= dy2 * $signed(ab_rd[3+n]);
    end
  end

  // product sums with the rounding half
  always_ff @(posedge clk) begin
    if (rst) begin
      s4 <= '0;
    end else begin
      s4 <= s3;
    end
    base_x4 <= base_x3;
    base_y4 <= base_y3;
    for (int n = 0; n < 3; n++) begin
      sx4[n] <= WIDE'(pxa[n]) + WIDE'(pxb[n]) + RND_HALF;
      sy4[n] <= WIDE'(pya[n]) + WIDE'(pyb[n]) + RND_HALF;
    end
  end

  // round, add the first vertex to the offset terms, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      s5 <= '0;
    end else begin
      s5 <= s4;
    end
    for (int n = 0; n < 3; n++) begin
      coef5[n]   <= round_add_sat_f(sx4[n], (n == 0) ? base_x4 : 32'sd0);
      coef5[3+n] <= round_add_sat_f(sy4[n], (n == 0) ? base_y4 : 32'sd0);
    end
  end

endmodule

// File: sv/pawm_map_eval.sv
module pawm_map_eval import pawm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   unwarp_mode,
  input  item_t  s5,
  input  word6_t coef5,
  output logic   push,
  output map_t   res
);

  word6_t coef_mem [MAX_TRIANGLES];
  word6_t cm_rd;

  item_t s6, s7, s8;
  logic signed [63:0] m1x, m2x, m1y, m2y;
  word_t c0_7, c3_7, c0_8, c3_8;
  logic signed [WIDE-1:0] sx8, sy8;
  logic  outside;
  word_t mark;

  // coefficient store: vertex set writes, pixel reads, same stage
  always_ff @(posedge clk) begin
    if (s5.valid && s5.cmd == CMD_VERTEX && s5.in_range) begin
      coef_mem[s5.addr] <= coef5;
    end
    cm_rd <= coef_mem[s5.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6 <= '0;
    end else begin
      s6 <= s5;
    end
  end

  // scale terms times pixel position
  always_ff @(posedge clk) begin
    if (rst) begin
      s7 <= '0;
    end else begin
      s7 <= s6;
    end
    m1x  <= $signed(cm_rd[1]) * s6.xi;
    m2x  <= $signed(cm_rd[2]) * s6.yi;
    m1y  <= $signed(cm_rd[4]) * s6.xi;
    m2y  <= $signed(cm_rd[5]) * s6.yi;
    c0_7 <= cm_rd[0];
    c3_7 <= cm_rd[3];
  end

  // product sums with the rounding half
  always_ff @(posedge clk) begin
    if (rst) begin
      s8 <= '0;
    end else begin
      s8 <= s7;
    end
    sx8  <= WIDE'(m1x) + WIDE'(m2x) + RND_HALF;
    sy8  <= WIDE'(m1y) + WIDE'(m2y) + RND_HALF;
    c0_8 <= c0_7;
    c3_8 <= c3_7;
  end

  // final round and offset, or the outside marker
  always_comb begin
    outside = !s8.on || !s8.in_range;
    mark    = unwarp_mode ? MARK_UNWARP : MARK_WARP;
    push    = s8.valid && s8.cmd == CMD_PIXEL;
    if (outside) begin
      res.x = mark;
      res.y = mark;
    end else begin
      res.x = round_add_sat_f(sx8, c0_8);
      res.y = round_add_sat_f(sy8, c3_8);
    end
  end

endmodule

// File: sv/pawm_out_fifo.sv
module pawm_out_fifo import pawm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  map_t  wdata,
  output logic  map_valid,
  input  logic  map_ready,
  output word_t map_x,
  output word_t map_y
);

  map_t entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [CREDIT_W-1:0] count;
  logic pop;

  assign pop       = map_valid && map_ready;
  assign map_valid = (count != '0);
  assign map_x     = entries[rd_ptr].x;
  assign map_y     = entries[rd_ptr].y;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + CREDIT_W'(push) - CREDIT_W'(pop);
    end
  end

endmodule

// File: sv/piecewise_affine_warp_map.sv
// Piecewise affine warp map generator, signed fixed point coordinates.
// Command channel (cmd_valid/cmd_ready): load alpha/beta terms of a triangle,
// set a triangle's vertices (computes and stores six coefficients), or map
// one pixel. Only pixel commands produce a transaction on the map channel
// (map_valid/map_ready with map_x, map_y).
// Throughput: one command per cycle while cmd_ready is high, any mix of
// commands. Pixel results reach the map channel through the queue; loads
// and vertex sets run down the same eight-stage pipeline, so a pixel may
// follow the vertex set of its triangle in the very next cycle.
// Results wait in a 16-entry queue. cmd_ready drops while 16 pixel results
// are in flight or queued; a stalled receiver therefore backs the block up
// without loss, and ready returns in the cycle after the queue drains a slot.
// Configuration goes through the APB port (x_offset at 0x0, y_offset at 0x4,
// unwarp_mode at 0x8); the user writes it only while the block is idle;
// the block does not enforce this. Reset clears the pipeline, the queue
// and the registers; the triangle stores hold nothing defined until loaded.
`include "piecewise_affine_warp_map_macros.svh"

module piecewise_affine_warp_map import pawm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [1:0]        command,
  input  logic [6:0]        tri_index,
  input  logic              pixel_on,
  input  logic signed [31:0] value_0,
  input  logic signed [31:0] value_1,
  input  logic signed [31:0] value_2,
  input  logic signed [31:0] value_3,
  input  logic signed [31:0] value_4,
  input  logic signed [31:0] value_5,
  output logic              map_valid,
  input  logic              map_ready,
  output logic signed [31:0] map_x,
  output logic signed [31:0] map_y
);

  word_t    x_offset, y_offset;
  logic     unwarp_mode;
  reg_idx_t reg_idx;
  logic     cfg_we;

  item_t  s1, s1_next, s5;
  word6_t vals1, coef5;
  logic   push;
  map_t   res;

  logic [CREDIT_W-1:0] credits, credits_next;
  logic accept, pop;

  // register access
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset    <= '0;
      y_offset    <= '0;
      unwarp_mode <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_X_OFFSET:    x_offset    <= pwdata;
        REG_Y_OFFSET:    y_offset    <= pwdata;
        REG_UNWARP_MODE: unwarp_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_OFFSET:    prdata = x_offset;
      REG_Y_OFFSET:    prdata = y_offset;
      REG_UNWARP_MODE: prdata = {31'b0, unwarp_mode};
      default:         prdata = '0;
    endcase
  end

  // credit count: pixels in flight plus results queued
  assign accept    = cmd_valid && cmd_ready;
  assign pop       = map_valid && map_ready;
  assign cmd_ready = (credits != CREDIT_W'(FIFO_DEPTH));
  assign credits_next = credits + CREDIT_W'(accept && command == CMD_PIXEL)
                        - CREDIT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits_next;
    end
  end

  // input stage, pixel position offset into fixed point
  always_comb begin
    s1_next.valid    = accept;
    s1_next.cmd      = cmd_t'(command);
    s1_next.addr     = TRI_AW'(tri_index);
    s1_next.in_range = (32'(tri_index) < 32'(MAX_TRIANGLES));
    s1_next.on       = pixel_on;
    s1_next.xi       = sat_sym_f((WIDE'(value_0) <<< FRAC_BITS) + WIDE'(x_offset));
    s1_next.yi       = sat_sym_f((WIDE'(value_1) <<< FRAC_BITS) + WIDE'(y_offset));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= s1_next;
    end
    vals1 <= {value_5, value_4, value_3, value_2, value_1, value_0};
  end

  pawm_coef_gen u_coef_gen (
    .clk   (clk),
    .rst   (rst),
    .s1    (s1),
    .vals1 (vals1),
    .s5    (s5),
    .coef5 (coef5)
  );

  pawm_map_eval u_map_eval (
    .clk         (clk),
    .rst         (rst),
    .unwarp_mode (unwarp_mode),
    .s5          (s5),
    .coef5       (coef5),
    .push        (push),
    .res         (res)
  );

  pawm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (res),
    .map_valid (map_valid),
    .map_ready (map_ready),
    .map_x     (map_x),
    .map_y     (map_y)
  );

  // credits never exceed queue capacity
  `PAWM_CHECK_NOW(credit_bound_a, 1'b1, credits <= CREDIT_W'(FIFO_DEPTH), "credits over queue depth")
  // a queued result always holds a credit
  `PAWM_CHECK_NOW(no_credit_empty_a, credits == '0, !map_valid, "result with no credit held")
  // an accepted pixel holds a credit next cycle
  `PAWM_CHECK_NEXT(pixel_credit_a, accept && command == CMD_PIXEL, credits != '0, "pixel lost its credit")
  // a full credit count must have turned the command channel away
  `PAWM_CHECK_NEXT(full_stall_a, credits == CREDIT_W'(FIFO_DEPTH) && !pop, !cmd_ready, "ready with queue full")

endmodule
